// ===== sv/dsr_pkg.sv =====
// Package for the diversity replacement selector.
// Holds field widths, request and register codes, and shared constants.
// No dependencies.
package dsr_pkg;

    localparam int POP_MAX_DEF   = 16;
    localparam int NODES_MAX_DEF = 256;

    localparam int FIT_W    = 48;
    localparam int DIST_W   = 9;
    localparam int LFSR_W   = 16;
    localparam int REQ_W    = 2;
    localparam int S_DATA_W = 72;   // 69 bits of fields padded to bytes
    localparam int M_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [FIT_W-1:0]  FIT_MAX   = '1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_RST  = 16'h0001;

    typedef logic [REQ_W-1:0] req_t;
    localparam req_t REQ_FIT  = 2'd0;
    localparam req_t REQ_NODE = 2'd1;
    localparam req_t REQ_RUN  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_POP  = 2'd0;
    localparam cfg_idx_t CFG_NODE = 2'd1;
    localparam cfg_idx_t CFG_PEN  = 2'd2;
    localparam cfg_idx_t CFG_SEED = 2'd3;

endpackage

// ===== sv/dsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/diversity_replacement_select.sv =====
// Diversity replacement selector, top level.
// Depends on dsr_pkg and dsr_ram.
//
// Usage:
// - s_ channel: one word per request. tuser carries the request kind
//   (load fitness, load tour node, run). tdata carries individual, position,
//   node and fitness. Loads give no output.
// - A node load reads the previous and the first tour node back from the
//   single-read-port tour memory before the successor writes.
// - A run copies and scans fitness (c = 2*pop_size), makes each pick by
//   stepping, scaling and selecting, then per round for each non-survivor
//   walks the edges of its tour (one tour read and two successor reads per
//   edge) and runs pairwise dominance checks through the candidate memory.
//   Survivors then leave in ascending index order, tlast on the final one.
// - m_ channel: output register; a stalled receiver holds the scan, the
//   block otherwise returns to idle and takes new words while the final
//   word is still waiting.
// - cfg channel is always ready; write only while idle. Writing the seed
//   reloads the LFSR.
// - Reset (aresetn low, synchronous) returns the FSM to idle and the
//   registers to their defaults. Store contents are not cleared.
module diversity_replacement_select #(
    parameter int POP_MAX   = dsr_pkg::POP_MAX_DEF,
    parameter int NODES_MAX = dsr_pkg::NODES_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [4:0] individual, [12:5] position, [20:13] node, [68:21] fitness
    input  logic [dsr_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [dsr_pkg::REQ_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [4:0] survivor_index
    output logic [dsr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dsr_pkg::*;

    localparam int CAND_MAX = 2 * POP_MAX;
    localparam int CW  = $clog2(CAND_MAX);
    localparam int IW  = CW + 1;
    localparam int NW  = $clog2(NODES_MAX);
    localparam int NCW = $clog2(NODES_MAX + 1);
    localparam int PW  = $clog2(POP_MAX + 1);
    localparam int TAW = CW + NW;
    localparam int CDW = FIT_W + DIST_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LD_RD = 5'd1;
    localparam logic [4:0] S_LD_WP = 5'd2;
    localparam logic [4:0] S_LD_WF = 5'd3;
    localparam logic [4:0] S_IN_RD = 5'd4;
    localparam logic [4:0] S_IN_WR = 5'd5;
    localparam logic [4:0] S_PK1   = 5'd6;
    localparam logic [4:0] S_PK2   = 5'd7;
    localparam logic [4:0] S_PK3   = 5'd8;
    localparam logic [4:0] S_DI    = 5'd9;
    localparam logic [4:0] S_DT0   = 5'd10;
    localparam logic [4:0] S_DEA   = 5'd11;
    localparam logic [4:0] S_DEB   = 5'd12;
    localparam logic [4:0] S_DEC   = 5'd13;
    localparam logic [4:0] S_DUPD  = 5'd14;
    localparam logic [4:0] S_PI    = 5'd15;
    localparam logic [4:0] S_PIW   = 5'd16;
    localparam logic [4:0] S_PJ    = 5'd17;
    localparam logic [4:0] S_PJW   = 5'd18;
    localparam logic [4:0] S_PEND  = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;

    // input fields
    logic [4:0]       in_ind;
    logic [7:0]       in_pos, in_node;
    logic [FIT_W-1:0] in_fit;
    assign in_ind  = s_tdata[4:0];
    assign in_pos  = s_tdata[12:5];
    assign in_node = s_tdata[20:13];
    assign in_fit  = s_tdata[68:21];

    // registers
    logic [4:0]        state_reg, state_next;
    logic [4:0]        pop_reg, pop_next;
    logic [8:0]        nodes_reg, nodes_next;
    logic [8:0]        pen_reg, pen_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [CW-1:0]     ld_ind_reg, ld_ind_next;
    logic [NW-1:0]     ld_pos_reg, ld_pos_next;
    logic [NW-1:0]     ld_node_reg, ld_node_next;
    logic              ld_last_reg, ld_last_next;
    logic [IW-1:0]     i_reg, i_next, j_reg, j_next;
    logic [NCW-1:0]    k_reg, k_next, common_reg, common_next;
    logic [FIT_W-1:0]  best_reg, best_next, fi_reg, fi_next;
    logic [DIST_W-1:0] di_reg, di_next;
    logic [IW-1:0]     nlist_reg, nlist_next;
    logic [CW-1:0]     clist_reg [CAND_MAX];
    logic [CW-1:0]     clist_next [CAND_MAX];
    logic [CAND_MAX-1:0] surv_reg, surv_next, dom_reg, dom_next;
    logic [CW-1:0]     last_reg, last_next, pick_reg, pick_next;
    logic [PW-1:0]     kept_reg, kept_next;
    logic [NW-1:0]     t0_reg, t0_next, a_reg, a_next, b_reg, b_next;
    logic              hit1_reg, hit1_next;
    logic              m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [4:0]        m_idx_reg, m_idx_next;

    // memory ports
    logic              fit_we, fit_re;
    logic [CW-1:0]     fit_waddr, fit_raddr;
    logic [FIT_W-1:0]  fit_rdata;
    logic              tour_we, tour_re;
    logic [TAW-1:0]    tour_waddr, tour_raddr;
    logic [NW-1:0]     tour_wdata, tour_rdata;
    logic              succ_we, succ_re;
    logic [TAW-1:0]    succ_waddr, succ_raddr;
    logic [NW-1:0]     succ_wdata, succ_rdata;
    logic              cand_we, cand_re;
    logic [CW-1:0]     cand_waddr, cand_raddr;
    logic [CDW-1:0]    cand_wdata, cand_rdata;

    dsr_ram #(.WIDTH(FIT_W), .DEPTH(CAND_MAX)) u_fit_ram (
        .clk(aclk), .we(fit_we), .waddr(fit_waddr), .wdata(in_fit),
        .re(fit_re), .raddr(fit_raddr), .rdata(fit_rdata)
    );
    dsr_ram #(.WIDTH(NW), .DEPTH(CAND_MAX << NW)) u_tour_ram (
        .clk(aclk), .we(tour_we), .waddr(tour_waddr), .wdata(tour_wdata),
        .re(tour_re), .raddr(tour_raddr), .rdata(tour_rdata)
    );
    dsr_ram #(.WIDTH(NW), .DEPTH(CAND_MAX << NW)) u_succ_ram (
        .clk(aclk), .we(succ_we), .waddr(succ_waddr), .wdata(succ_wdata),
        .re(succ_re), .raddr(succ_raddr), .rdata(succ_rdata)
    );
    dsr_ram #(.WIDTH(CDW), .DEPTH(CAND_MAX)) u_cand_ram (
        .clk(aclk), .we(cand_we), .waddr(cand_waddr), .wdata(cand_wdata),
        .re(cand_re), .raddr(cand_raddr), .rdata(cand_rdata)
    );

    // effective configuration
    logic [PW-1:0]  p_eff;
    logic [IW-1:0]  c_eff;
    logic [NCW-1:0] n_eff;
    always_comb begin
        if (pop_reg == 5'd0) begin
            p_eff = PW'(1);
        end else if (32'(pop_reg) < POP_MAX) begin
            p_eff = PW'(pop_reg);
        end else begin
            p_eff = PW'(POP_MAX);
        end
        c_eff = IW'({p_eff, 1'b0});
        n_eff = (32'(nodes_reg) < NODES_MAX) ? NCW'(nodes_reg) : NCW'(NODES_MAX);
    end

    // local helpers
    logic [CW-1:0]         i_idx, j_idx;
    logic                  last_edge;
    logic [NW-1:0]         b_cur;
    logic [LFSR_W+IW-1:0]  prod;
    logic [NCW-1:0]        tour_dist;
    logic [DIST_W-1:0]     old_d, new_d, cd_d;
    logic [FIT_W-1:0]      old_f, cd_f;
    logic                  slot_free;
    logic [CAND_MAX-1:0]   above;

    assign i_idx     = i_reg[CW-1:0];
    assign j_idx     = j_reg[CW-1:0];
    assign last_edge = (k_reg + NCW'(1)) == n_eff;
    assign b_cur     = last_edge ? t0_reg : tour_rdata;
    assign prod      = (LFSR_W + IW)'(lfsr_reg) * (LFSR_W + IW)'(nlist_reg);
    assign tour_dist = n_eff - common_reg;
    assign old_d     = cand_rdata[DIST_W-1:0];
    assign old_f     = cand_rdata[CDW-1:DIST_W];
    assign cd_d      = cand_rdata[DIST_W-1:0];
    assign cd_f      = cand_rdata[CDW-1:DIST_W];
    assign new_d     = (32'(tour_dist) < 32'(old_d)) ? DIST_W'(tour_dist) : old_d;
    assign slot_free = !m_valid_reg || m_tready;
    assign above     = surv_reg >> (i_reg + IW'(1));

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_DATA_W'(m_idx_reg);
    assign m_tlast   = m_last_reg;

    always_comb begin
        state_next   = state_reg;
        pop_next     = pop_reg;
        nodes_next   = nodes_reg;
        pen_next     = pen_reg;
        lfsr_next    = lfsr_reg;
        ld_ind_next  = ld_ind_reg;
        ld_pos_next  = ld_pos_reg;
        ld_node_next = ld_node_reg;
        ld_last_next = ld_last_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        common_next  = common_reg;
        best_next    = best_reg;
        fi_next      = fi_reg;
        di_next      = di_reg;
        nlist_next   = nlist_reg;
        clist_next   = clist_reg;
        surv_next    = surv_reg;
        dom_next     = dom_reg;
        last_next    = last_reg;
        pick_next    = pick_reg;
        kept_next    = kept_reg;
        t0_next      = t0_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        hit1_next    = hit1_reg;
        m_valid_next = m_valid_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;

        fit_we = 1'b0;  fit_waddr = CW'(in_ind);  fit_re = 1'b0;  fit_raddr = i_idx;
        tour_we = 1'b0; tour_waddr = {CW'(in_ind), NW'(in_pos)};
        tour_wdata = NW'(in_node);
        tour_re = 1'b0; tour_raddr = {i_idx, NW'(0)};
        succ_we = 1'b0; succ_waddr = {ld_ind_reg, ld_node_reg};
        succ_wdata = ld_node_reg;
        succ_re = 1'b0; succ_raddr = {last_reg, a_reg};
        cand_we = 1'b0; cand_waddr = i_idx; cand_wdata = {fit_rdata, DIST_MAX};
        cand_re = 1'b0; cand_raddr = i_idx;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_POP:  pop_next   = cfg_data[4:0];
                CFG_NODE: nodes_next = cfg_data[8:0];
                CFG_PEN:  pen_next   = cfg_data[8:0];
                CFG_SEED: lfsr_next  = cfg_data;
                default:  ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        REQ_FIT: begin
                            fit_we = (32'(in_ind) < CAND_MAX);
                        end
                        REQ_NODE: begin
                            if (32'(in_ind) < CAND_MAX && 32'(in_pos) < 32'(n_eff)
                                && 32'(in_node) < NODES_MAX) begin
                                tour_we      = 1'b1;
                                ld_ind_next  = CW'(in_ind);
                                ld_pos_next  = NW'(in_pos);
                                ld_node_next = NW'(in_node);
                                ld_last_next = (32'(in_pos) + 32'd1) == 32'(n_eff);
                                state_next   = S_LD_RD;
                            end
                        end
                        REQ_RUN: begin
                            i_next     = '0;
                            surv_next  = '0;
                            kept_next  = '0;
                            state_next = S_IN_RD;
                        end
                        default: ;
                    endcase
                end
            end
            // successor writes need the stored neighbors
            S_LD_RD: begin
                if (ld_pos_reg != '0) begin
                    tour_re    = 1'b1;
                    tour_raddr = {ld_ind_reg, ld_pos_reg - NW'(1)};
                    state_next = S_LD_WP;
                end else if (ld_last_reg) begin
                    tour_re    = 1'b1;
                    tour_raddr = {ld_ind_reg, NW'(0)};
                    state_next = S_LD_WF;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_LD_WP: begin
                succ_we    = 1'b1;
                succ_waddr = {ld_ind_reg, tour_rdata};
                succ_wdata = ld_node_reg;
                if (ld_last_reg) begin
                    tour_re    = 1'b1;
                    tour_raddr = {ld_ind_reg, NW'(0)};
                    state_next = S_LD_WF;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_LD_WF: begin
                succ_we    = 1'b1;
                succ_waddr = {ld_ind_reg, ld_node_reg};
                succ_wdata = tour_rdata;
                state_next = S_IDLE;
            end
            // copy fitness, seed distances, collect lowest-fitness ties
            S_IN_RD: begin
                fit_re     = 1'b1;
                state_next = S_IN_WR;
            end
            S_IN_WR: begin
                cand_we = 1'b1;
                if (i_reg == '0 || fit_rdata < best_reg) begin
                    best_next     = fit_rdata;
                    nlist_next    = IW'(1);
                    clist_next[0] = i_idx;
                end else if (fit_rdata == best_reg) begin
                    clist_next[nlist_reg[CW-1:0]] = i_idx;
                    nlist_next = nlist_reg + IW'(1);
                end
                i_next     = i_reg + IW'(1);
                state_next = ((i_reg + IW'(1)) == c_eff) ? S_PK1 : S_IN_RD;
            end
            // random pick: step LFSR, scale, select
            S_PK1: begin
                if (nlist_reg == '0) begin
                    clist_next[0] = '0;
                    nlist_next    = IW'(1);
                end
                lfsr_next  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
                state_next = S_PK2;
            end
            S_PK2: begin
                pick_next  = prod[LFSR_W +: CW];
                state_next = S_PK3;
            end
            S_PK3: begin
                last_next = clist_reg[pick_reg];
                surv_next[clist_reg[pick_reg]] = 1'b1;
                kept_next = kept_reg + PW'(1);
                i_next    = '0;
                state_next = ((kept_reg + PW'(1)) < p_eff) ? S_DI : S_OUT;
            end
            // distance refresh against the newest survivor
            S_DI: begin
                if (i_reg == c_eff) begin
                    i_next     = '0;
                    dom_next   = '0;
                    nlist_next = '0;
                    state_next = S_PI;
                end else if (surv_reg[i_idx]) begin
                    i_next = i_reg + IW'(1);
                end else begin
                    tour_re    = 1'b1;
                    tour_raddr = {i_idx, NW'(0)};
                    cand_re    = 1'b1;
                    state_next = S_DT0;
                end
            end
            S_DT0: begin
                t0_next     = tour_rdata;
                a_next      = tour_rdata;
                k_next      = '0;
                common_next = '0;
                state_next  = (n_eff == '0) ? S_DUPD : S_DEA;
            end
            S_DEA: begin
                if (!last_edge) begin
                    tour_re    = 1'b1;
                    tour_raddr = {i_idx, NW'(k_reg + NCW'(1))};
                end
                succ_re    = 1'b1;
                succ_raddr = {last_reg, a_reg};
                state_next = S_DEB;
            end
            S_DEB: begin
                b_next     = b_cur;
                hit1_next  = (succ_rdata == b_cur);
                succ_re    = 1'b1;
                succ_raddr = {last_reg, b_cur};
                state_next = S_DEC;
            end
            S_DEC: begin
                if (hit1_reg || succ_rdata == a_reg) begin
                    common_next = common_reg + NCW'(1);
                end
                a_next     = b_reg;
                k_next     = k_reg + NCW'(1);
                state_next = last_edge ? S_DUPD : S_DEA;
            end
            S_DUPD: begin
                cand_we    = 1'b1;
                cand_wdata = {(new_d <= pen_reg) ? FIT_MAX : old_f, new_d};
                i_next     = i_reg + IW'(1);
                state_next = S_DI;
            end
            // pairwise non-dominance filter
            S_PI: begin
                if (i_reg == c_eff) begin
                    state_next = S_PK1;
                end else if (surv_reg[i_idx] || dom_reg[i_idx]) begin
                    i_next = i_reg + IW'(1);
                end else begin
                    cand_re    = 1'b1;
                    state_next = S_PIW;
                end
            end
            S_PIW: begin
                fi_next    = cd_f;
                di_next    = cd_d;
                j_next     = i_reg + IW'(1);
                state_next = S_PJ;
            end
            S_PJ: begin
                if (j_reg == c_eff) begin
                    state_next = S_PEND;
                end else if (surv_reg[j_idx] || dom_reg[j_idx]) begin
                    j_next = j_reg + IW'(1);
                end else begin
                    cand_re    = 1'b1;
                    cand_raddr = j_idx;
                    state_next = S_PJW;
                end
            end
            S_PJW: begin
                priority if ((cd_d == di_reg && cd_f == fi_reg)
                             || (di_reg >= cd_d && fi_reg <= cd_f)) begin
                    dom_next[j_idx] = 1'b1;
                    j_next     = j_reg + IW'(1);
                    state_next = S_PJ;
                end else if (cd_d >= di_reg && cd_f <= fi_reg) begin
                    dom_next[i_idx] = 1'b1;
                    state_next = S_PEND;
                end else begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_PJ;
                end
            end
            S_PEND: begin
                if (!dom_reg[i_idx]) begin
                    clist_next[nlist_reg[CW-1:0]] = i_idx;
                    nlist_next = nlist_reg + IW'(1);
                end
                i_next     = i_reg + IW'(1);
                state_next = S_PI;
            end
            // ascending survivor scan into the output register
            S_OUT: begin
                if (i_reg == c_eff) begin
                    state_next = S_IDLE;
                end else if (!surv_reg[i_idx]) begin
                    i_next = i_reg + IW'(1);
                end else if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = 5'(i_reg);
                    m_last_next  = (above == '0);
                    i_next       = i_reg + IW'(1);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pop_reg     <= 5'd16;
            nodes_reg   <= 9'd256;
            pen_reg     <= '0;
            lfsr_reg    <= LFSR_RST;
            m_valid_reg <= 1'b0;
            nlist_reg   <= '0;
            surv_reg    <= '0;
            dom_reg     <= '0;
            kept_reg    <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            pop_reg     <= pop_next;
            nodes_reg   <= nodes_next;
            pen_reg     <= pen_next;
            lfsr_reg    <= lfsr_next;
            m_valid_reg <= m_valid_next;
            nlist_reg   <= nlist_next;
            surv_reg    <= surv_next;
            dom_reg     <= dom_next;
            kept_reg    <= kept_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
        end
        ld_ind_reg  <= ld_ind_next;
        ld_pos_reg  <= ld_pos_next;
        ld_node_reg <= ld_node_next;
        ld_last_reg <= ld_last_next;
        common_reg  <= common_next;
        best_reg    <= best_next;
        fi_reg      <= fi_next;
        di_reg      <= di_next;
        clist_reg   <= clist_next;
        last_reg    <= last_next;
        pick_reg    <= pick_next;
        t0_reg      <= t0_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        hit1_reg    <= hit1_next;
        m_idx_reg   <= m_idx_next;
        m_last_reg  <= m_last_next;
    end

    // a nonzero LFSR never collapses to zero by stepping
    a_lfsr_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        (lfsr_reg != '0 && !cfg_valid) |=> (lfsr_reg != '0))
        else $error("lfsr stepped to zero");

    // the pick never scales over an empty list
    a_pick_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PK2) |-> (nlist_reg != '0))
        else $error("pick with empty candidate list");

    // a pick is only committed while survivors are still missing
    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PK3) |-> (kept_reg < p_eff))
        else $error("survivor count overflow");
endmodule
